FILE: rtl/core/dd_pkg.sv
`timescale 1ns / 1ps

package dd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned DNUM_W  = 23;
    localparam int unsigned DIFF_W  = 22;

    // floor(x / 25) == (x * RECIP_25) >> RECIP_SHIFT for every x below 4096
    localparam logic [15:0] RECIP_25    = 16'd41944;
    localparam int unsigned RECIP_SHIFT = 20;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef logic [DNUM_W-1:0] t_day_num;

    typedef struct packed {
        logic     valid;
        t_day_num day_num;
    } t_date_res;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/core/dd_ifs.sv
`timescale 1ns / 1ps

interface dd_req_if;
    logic                          valid;
    logic                          ready;
    logic [dd_pkg::DAY_W-1:0]      first_day;
    logic [dd_pkg::MONTH_W-1:0]    first_month;
    logic [dd_pkg::YEAR_W-1:0]     first_year;
    logic [dd_pkg::DAY_W-1:0]      second_day;
    logic [dd_pkg::MONTH_W-1:0]    second_month;
    logic [dd_pkg::YEAR_W-1:0]     second_year;

    modport source (output valid, first_day, first_month, first_year,
                    second_day, second_month, second_year, input ready);
    modport sink   (input valid, first_day, first_month, first_year,
                    second_day, second_month, second_year, output ready);
endinterface

interface dd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dd_pkg::DIFF_W-1:0]     day_difference;
    logic                          first_valid;
    logic                          second_valid;

    modport source (output valid, day_difference, first_valid, second_valid, input ready);
    modport sink   (input valid, day_difference, first_valid, second_valid, output ready);
endinterface

FILE: rtl/core/date_difference_in_days.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// i_req    in   valid/ready    first_/second_ day, month, year
// o_rsp    out  valid/ready    day_difference, first_valid, second_valid
//
// One request per cycle while o_rsp is not stalled; a request passes through
// the input register, then the result register after the day-number logic.
// Reset (i_rst_n low, synchronous) empties both registers.
// A stalled output holds its result; input keeps flowing while the input
// register can move into a free or draining result register.
module date_difference_in_days #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dd_req_if.sink      i_req,
    dd_rsp_if.source    o_rsp
);

    logic                          r_s1_valid;
    logic [dd_pkg::DAY_W-1:0]      r_d1;
    logic [dd_pkg::MONTH_W-1:0]    r_m1;
    logic [dd_pkg::YEAR_W-1:0]     r_y1;
    logic [dd_pkg::DAY_W-1:0]      r_d2;
    logic [dd_pkg::MONTH_W-1:0]    r_m2;
    logic [dd_pkg::YEAR_W-1:0]     r_y2;

    logic                          r_s2_valid;
    logic [dd_pkg::DIFF_W-1:0]     r_diff;
    logic                          r_v1;
    logic                          r_v2;

    logic                          s2_free;
    logic                          s1_adv;
    logic                          in_fire;
    dd_pkg::t_date_res             res1;
    dd_pkg::t_date_res             res2;
    dd_pkg::t_day_num              abs_diff;
    logic [dd_pkg::DIFF_W-1:0]     n_diff;

    assign s2_free     = !r_s2_valid || o_rsp.ready;
    assign s1_adv      = r_s1_valid && s2_free;
    assign i_req.ready = !r_s1_valid || s2_free;
    assign in_fire     = i_req.valid && i_req.ready;

    dd_date_conv #(.MAX_YEAR(MAX_YEAR)) u_conv1 (
        .i_day   (r_d1),
        .i_month (r_m1),
        .i_year  (r_y1),
        .o_res   (res1)
    );

    dd_date_conv #(.MAX_YEAR(MAX_YEAR)) u_conv2 (
        .i_day   (r_d2),
        .i_month (r_m2),
        .i_year  (r_y2),
        .o_res   (res2)
    );

    assign abs_diff = (res1.day_num > res2.day_num) ? (res1.day_num - res2.day_num)
                                                    : (res2.day_num - res1.day_num);

    always_comb begin
        if (!(res1.valid && res2.valid)) begin
            n_diff = '0;
        end else if (abs_diff[dd_pkg::DNUM_W-1]) begin
            n_diff = '1;   // only reachable with a raised year limit
        end else begin
            n_diff = abs_diff[dd_pkg::DIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_d1 <= i_req.first_day;
            r_m1 <= i_req.first_month;
            r_y1 <= i_req.first_year;
            r_d2 <= i_req.second_day;
            r_m2 <= i_req.second_month;
            r_y2 <= i_req.second_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_diff <= n_diff;
            r_v1   <= res1.valid;
            r_v2   <= res2.valid;
        end
    end

    assign o_rsp.valid          = r_s2_valid;
    assign o_rsp.day_difference = r_diff;
    assign o_rsp.first_valid    = r_v1;
    assign o_rsp.second_valid   = r_v2;

endmodule

FILE: rtl/core/dd_date_conv.sv
`timescale 1ns / 1ps

module dd_date_conv #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic [dd_pkg::DAY_W-1:0]   i_day,
    input  logic [dd_pkg::MONTH_W-1:0] i_month,
    input  logic [dd_pkg::YEAR_W-1:0]  i_year,
    output dd_pkg::t_date_res          o_res
);

    localparam logic [16:0] MaxYear = 17'(MAX_YEAR);

    logic [dd_pkg::YEAR_W-1:0] prev_year;
    logic [27:0]               y_prod;
    logic [27:0]               p_prod;
    logic [7:0]                y_cent;
    logic [7:0]                p_cent;
    logic                      leap;
    logic [dd_pkg::DAY_W-1:0]  len;
    logic                      ok;
    dd_pkg::t_day_num          base;

    assign prev_year = i_year - 14'd1;

    // year / 100 as (year / 4) / 25, for the year and the one before it
    assign y_prod = 28'(i_year[13:2])    * 28'(dd_pkg::RECIP_25);
    assign p_prod = 28'(prev_year[13:2]) * 28'(dd_pkg::RECIP_25);
    assign y_cent = y_prod[dd_pkg::RECIP_SHIFT +: 8];
    assign p_cent = p_prod[dd_pkg::RECIP_SHIFT +: 8];

    // the century count steps exactly at multiples of 100; likewise /400
    assign leap = (i_year[1:0] == 2'd0) &&
                  ((y_cent == p_cent) || (y_cent[7:2] != p_cent[7:2]));

    assign len = dd_pkg::month_len(i_month, leap);

    assign ok = (i_year != '0) && ({3'b000, i_year} <= MaxYear) &&
                (i_month >= dd_pkg::MONTH_JAN) && (i_month <= dd_pkg::MONTH_DEC) &&
                (i_day != '0) && (i_day <= len);

    assign base = 23'(prev_year) * 23'd365 + 23'(prev_year[13:2])
                - 23'(p_cent) + 23'(p_cent[7:2]);

    always_comb begin
        o_res.valid   = ok;
        o_res.day_num = base + 23'(dd_pkg::days_before_month(i_month))
                      + 23'((i_month > dd_pkg::MONTH_FEB) && leap) + 23'(i_day);
    end

endmodule

FILE: rtl/core/dd_chk.sv
`timescale 1ns / 1ps

module dd_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [dd_pkg::DIFF_W-1:0]  i_out_diff,
    input logic                       i_out_v1,
    input logic                       i_out_v2
);

    // an invalid date never yields a nonzero difference
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !(i_out_v1 && i_out_v2)) |-> (i_out_diff == '0))
        else $error("nonzero difference with an invalid date");

    // input only stalls when both registers are full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_diff) && $stable(i_out_v1) && $stable(i_out_v2)))
        else $error("stalled result changed");

endmodule

bind date_difference_in_days dd_chk u_dd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_diff  (o_rsp.day_difference),
    .i_out_v1    (o_rsp.first_valid),
    .i_out_v2    (o_rsp.second_valid)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned MAX_YEAR    = 9999;
    localparam int unsigned N_RANDOM    = 2000;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned N_DIRECTED  = 23;

    typedef logic [dd_pkg::DAY_W-1:0]   t_day;
    typedef logic [dd_pkg::MONTH_W-1:0] t_month;
    typedef logic [dd_pkg::YEAR_W-1:0]  t_year;
    typedef logic [dd_pkg::DIFF_W-1:0]  t_days;

    localparam t_days GAP_SAT = '1;

    typedef struct packed {
        t_day   day;
        t_month month;
        t_year  year;
    } t_date;

    typedef struct packed {
        t_date first_date;
        t_date second_date;
    } t_date_pair;

    typedef struct packed {
        t_days days;
        logic  first_ok;
        logic  second_ok;
    } t_day_gap;

    localparam int unsigned DAYS_AHEAD [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    // d1 m1 y1  d2 m2 y2  typed  days v1 v2   (typed = 0: predictor decides)
    int unsigned directed_tab [N_DIRECTED][10] = '{
        '{ 1,  1,     1,  1,  1,     1, 1,       0, 1, 1},
        '{ 1,  1,     1, 31, 12,  9999, 1, 3652058, 1, 1},
        '{31, 12,  9999,  1,  1,     1, 1, 3652058, 1, 1},
        '{ 0,  1,  2000,  1,  1,  2000, 1,       0, 0, 1},
        '{ 1,  0,  2000,  1,  1,  2000, 1,       0, 0, 1},
        '{ 1, 13,  2000,  1,  1,  2000, 1,       0, 0, 1},
        '{31, 15, 16383, 31, 15, 16383, 1,       0, 0, 0},
        '{ 0,  0,     0,  0,  0,     0, 1,       0, 0, 0},
        '{ 1,  1,     0,  1,  1,     1, 1,       0, 0, 1},
        '{ 1,  1, 10000,  1,  1,  9999, 1,       0, 0, 1},
        '{31,  4,  2021,  1,  5,  2021, 1,       0, 0, 1},
        '{29,  2,  1900,  1,  3,  1900, 1,       0, 0, 1},
        '{29,  2,  2001,  1,  3,  2001, 1,       0, 0, 1},
        '{ 1,  1,  2000,  0,  1,  2000, 1,       0, 1, 0},
        '{ 1,  3,  2000, 28,  2,  2000, 1,       2, 1, 1},
        '{ 1,  3,  1900, 28,  2,  1900, 1,       1, 1, 1},
        '{29,  2,  2000, 29,  2,  2004, 0,       0, 0, 0},
        '{29,  2,  2400,  1,  1,     1, 0,       0, 0, 0},
        '{31,  1,  8192, 30, 11,  4096, 0,       0, 0, 0},
        '{15,  6,  1970,  4,  7,  1776, 0,       0, 0, 0},
        '{31, 12,  2099,  1,  1,  2100, 0,       0, 0, 0},
        '{30,  9,  5555, 31, 10,  5555, 0,       0, 0, 0},
        '{16,  8, 10240, 16,  8,  2048, 0,       0, 0, 0}
    };

    logic i_clk;
    logic i_rst_n;

    dd_req_if req_if ();
    dd_rsp_if rsp_if ();

    date_difference_in_days #(
        .MAX_YEAR(MAX_YEAR)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_day_gap    gap_expected_q[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned ready_tick;
    t_day_gap    gap_want;
    t_day_gap    gap_got;

    // ---------------- predictor ----------------

    function automatic logic leap_year(input t_year y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input t_month m, input t_year y);
        case (m)
            4'd2:                      return leap_year(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        return 31;
            default:                   return 0;
        endcase
    endfunction

    function automatic logic date_valid(input t_date dt);
        return dt.year >= 1 && dt.year <= MAX_YEAR && dt.month >= dd_pkg::MONTH_JAN &&
               dt.month <= dd_pkg::MONTH_DEC && dt.day >= 1 &&
               dt.day <= days_in_month(dt.month, dt.year);
    endfunction

    // day 1 is 0001-01-01
    function automatic int unsigned serial_day(input t_date dt);
        int unsigned p;
        int unsigned n;
        p = dt.year - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400 + DAYS_AHEAD[dt.month - 4'd1];
        if (dt.month > dd_pkg::MONTH_FEB && leap_year(dt.year))
            n++;
        return n + dt.day;
    endfunction

    function automatic t_day_gap predict_gap(input t_date_pair pr);
        t_day_gap    g;
        int unsigned a;
        int unsigned b;
        int unsigned d;
        g.first_ok  = date_valid(pr.first_date);
        g.second_ok = date_valid(pr.second_date);
        g.days      = '0;
        if (g.first_ok && g.second_ok) begin
            a = serial_day(pr.first_date);
            b = serial_day(pr.second_date);
            d = (a > b) ? a - b : b - a;
            g.days = (d > GAP_SAT) ? GAP_SAT : d[dd_pkg::DIFF_W-1:0];
        end
        return g;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_date random_valid_date(input t_year y);
        t_date dt;
        dt.year  = y;
        dt.month = t_month'($urandom_range(1, 12));
        dt.day   = t_day'($urandom_range(1, days_in_month(dt.month, y)));
        return dt;
    endfunction

    function automatic t_date random_noise_date();
        t_date dt;
        dt.day   = t_day'($urandom);
        dt.month = t_month'($urandom);
        dt.year  = t_year'($urandom);
        return dt;
    endfunction

    function automatic t_date_pair random_pair();
        t_date_pair pr;
        int unsigned sel;
        int unsigned y;
        int unsigned centuries [5] = '{1600, 1900, 2000, 2100, 2400};
        sel = $urandom_range(0, 19);
        if (sel <= 11) begin
            pr.first_date  = random_valid_date(t_year'($urandom_range(1, MAX_YEAR)));
            pr.second_date = random_valid_date(t_year'($urandom_range(1, MAX_YEAR)));
        end else if (sel <= 14) begin
            // nearby years
            y = $urandom_range(2, MAX_YEAR - 1);
            pr.first_date  = random_valid_date(t_year'(y));
            pr.second_date = random_valid_date(t_year'(y + $urandom_range(0, 2) - 1));
        end else if (sel <= 16) begin
            // February edge around century and leap years
            y = ($urandom_range(0, 1) == 0) ? centuries[$urandom_range(0, 4)]
                                            : $urandom_range(1, MAX_YEAR / 4) * 4;
            pr.first_date.year   = t_year'(y + $urandom_range(0, 1));
            pr.first_date.month  = dd_pkg::MONTH_FEB;
            pr.first_date.day    = t_day'($urandom_range(28, 29));
            pr.second_date.year  = t_year'(y);
            pr.second_date.month = 4'd3;
            pr.second_date.day   = 5'd1;
        end else if (sel <= 18) begin
            pr.first_date  = random_noise_date();
            pr.second_date = random_valid_date(t_year'($urandom_range(1, MAX_YEAR)));
            if ($urandom_range(0, 1) == 1)
                pr = {pr.second_date, pr.first_date};
        end else begin
            pr.first_date  = random_noise_date();
            pr.second_date = random_noise_date();
        end
        return pr;
    endfunction

    task automatic send_request(input t_date_pair pr, input t_day_gap want);
        int unsigned idle;
        if (burst_left == 0) begin
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (idle) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        req_if.valid        <= 1'b1;
        req_if.first_day    <= pr.first_date.day;
        req_if.first_month  <= pr.first_date.month;
        req_if.first_year   <= pr.first_date.year;
        req_if.second_day   <= pr.second_date.day;
        req_if.second_month <= pr.second_date.month;
        req_if.second_year  <= pr.second_date.year;
        do @(posedge i_clk); while (!req_if.ready);
        gap_expected_q.push_back(want);
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (gap_expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------- clock, reset, receiver ----------------

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver ready: cycles through open, random and periodic stall phases
    always @(negedge i_clk) begin
        ready_tick <= ready_tick + 1;
        case (ready_tick[9:8])
            2'd0:    rsp_if.ready <= 1'b1;
            2'd1:    rsp_if.ready <= ($urandom_range(0, 1) == 1);
            2'd2:    rsp_if.ready <= (ready_tick % 3 == 0);
            default: rsp_if.ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // ---------------- result check ----------------

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, gap_expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end else if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            gap_got = '{rsp_if.day_difference, rsp_if.first_valid, rsp_if.second_valid};
            if (gap_expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result days=%0d v1=%0b v2=%0b", $realtime,
                             gap_got.days, gap_got.first_ok, gap_got.second_ok);
            end else begin
                gap_want = gap_expected_q.pop_front();
                if (gap_got !== gap_want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: days exp %0d got %0d, ",
                                  "v1 exp %0b got %0b, v2 exp %0b got %0b"},
                                 $realtime, gap_want.days, gap_got.days, gap_want.first_ok,
                                 gap_got.first_ok, gap_want.second_ok, gap_got.second_ok);
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        t_date_pair pr;
        t_day_gap   want;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.first_day    = '0;
        req_if.first_month  = '0;
        req_if.first_year   = '0;
        req_if.second_day   = '0;
        req_if.second_month = '0;
        req_if.second_year  = '0;
        rsp_if.ready        = 1'b0;
        ready_tick          = 0;
        cycle_count         = 0;
        mismatch_count      = 0;
        burst_left          = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            pr.first_date.day    = t_day'(directed_tab[i][0]);
            pr.first_date.month  = t_month'(directed_tab[i][1]);
            pr.first_date.year   = t_year'(directed_tab[i][2]);
            pr.second_date.day   = t_day'(directed_tab[i][3]);
            pr.second_date.month = t_month'(directed_tab[i][4]);
            pr.second_date.year  = t_year'(directed_tab[i][5]);
            if (directed_tab[i][6] != 0)
                want = '{t_days'(directed_tab[i][7]), 1'(directed_tab[i][8]),
                         1'(directed_tab[i][9])};
            else
                want = predict_gap(pr);
            send_request(pr, want);
        end
        wait_all_results();

        for (int i = 0; i < N_RANDOM; i++) begin
            pr = random_pair();
            send_request(pr, predict_gap(pr));
            if (i % 500 == 499)
                wait_all_results();
        end
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
